/* rtl/core/ihts_pkg.sv */
// shared types and constants of the interrupt handler time statistics block
package ihts_pkg;

	localparam int NUM_LINES_DEF = 128;
	localparam int LINE_W = 7;
	localparam int CYC_W = 32;
	localparam int RATE_W = 16;
	localparam logic [RATE_W-1:0] RATE_RESET = 16'd24;

	// divider runs two quotient bits per step
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] DIV1_STEPS = 5'd16;
	localparam logic [STEP_W-1:0] DIV2_STEPS = 5'd9;

	typedef struct packed {
		logic [31:0] runs;
		logic [31:0] worst;
		logic [31:0] usec;
		logic [15:0] rem;
	} rec_t;

	typedef struct packed {
		logic take;
		logic clr_wr;
		logic rd;
		logic eval;
		logic start_div1;
		logic start_div2;
		logic wr;
		logic load_out;
	} ihts_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_busy;
		logic skip;
	} ihts_sts_t;

endpackage

/* rtl/core/ihts_if.sv */
// request and response channel interfaces

interface ihts_req_if
	import ihts_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [LINE_W-1:0] irq_number;
	logic [CYC_W-1:0]  handler_cycles;

	modport source (output valid, kind, irq_number, handler_cycles, input ready);
	modport sink (input valid, kind, irq_number, handler_cycles, output ready);
endinterface

interface ihts_rsp_if
	import ihts_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [LINE_W-1:0] line_echo;
	logic [31:0]       run_count;
	logic [31:0]       worst_cycles;
	logic [31:0]       total_microseconds;
	logic [15:0]       leftover_cycles;

	modport source (output valid, line_echo, run_count, worst_cycles, total_microseconds,
		leftover_cycles, input ready);
	modport sink (input valid, line_echo, run_count, worst_cycles, total_microseconds,
		leftover_cycles, output ready);
endinterface

/* rtl/core/ihts_div.sv */
// radix-4 restoring divider, 32-bit dividend by 16-bit divisor
module ihts_div
	import ihts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       dividend,
	input  logic [15:0]       divisor,
	input  logic [STEP_W-1:0] steps,
	output logic              busy,
	output logic [31:0]       quot,
	output logic [15:0]       rem
);

	logic [STEP_W-1:0] cnt_q;
	logic [31:0]       sh_q;
	logic [15:0]       rem_q;
	logic [15:0]       d_q;

	logic [16:0] t1, t2;
	logic        ge1, ge2;
	logic [15:0] r1, r2;

	always_comb begin
		t1  = {rem_q, sh_q[31]};
		ge1 = t1 >= {1'b0, d_q};
		r1  = ge1 ? 16'(t1 - {1'b0, d_q}) : t1[15:0];
		t2  = {r1, sh_q[30]};
		ge2 = t2 >= {1'b0, d_q};
		r2  = ge2 ? 16'(t2 - {1'b0, d_q}) : t2[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (cnt_q != '0) begin
			// quotient bits enter at the bottom as the dividend leaves the top
			sh_q  <= {sh_q[29:0], ge1, ge2};
			rem_q <= r2;
		end
	end

	assign busy = cnt_q != '0;
	assign quot = sh_q;
	assign rem  = rem_q;

endmodule

/* rtl/core/ihts_dp.sv */
// datapath: statistics memory, item registers, divider and response register
module ihts_dp
	import ihts_pkg::*;
#(
	parameter int NUM_LINES = NUM_LINES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_wdata,
	input  ihts_cmd_t         cmd,
	output ihts_sts_t         sts,
	input  logic              req_kind,
	input  logic [LINE_W-1:0] req_irq_number,
	input  logic [CYC_W-1:0]  req_handler_cycles,
	output logic [LINE_W-1:0] rsp_line_echo,
	output logic [31:0]       rsp_run_count,
	output logic [31:0]       rsp_worst_cycles,
	output logic [31:0]       rsp_total_microseconds,
	output logic [15:0]       rsp_leftover_cycles
);

	localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int EXT_W = (IDX_W > LINE_W) ? IDX_W : LINE_W;
	localparam int CMP_W = 12;

	rec_t mem [NUM_LINES];

	logic [RATE_W-1:0] rate_q;
	logic [IDX_W-1:0]  clr_q;
	logic              kind_q;
	logic [LINE_W-1:0] line_q;
	logic [CYC_W-1:0]  cyc_q;
	logic              in_range_q;
	rec_t              rd_q;
	rec_t              rec_q;
	rec_t              rec_new;

	logic [RATE_W-1:0] rate_eff;
	logic [EXT_W-1:0]  line_ext;
	logic [IDX_W-1:0]  line_idx;
	logic [16:0]       sum;
	logic              div_start;
	logic [31:0]       div_dividend;
	logic [STEP_W-1:0] div_steps;
	logic              div_busy;
	logic [31:0]       div_quot;
	logic [15:0]       div_rem;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_addr;
	rec_t              mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			clr_q  <= '0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;
	assign line_ext = EXT_W'(line_q);
	assign line_idx = line_ext[IDX_W-1:0];

	// old remainder plus this run's remainder, below twice the largest rate
	assign sum = {1'b0, rec_q.rem} + {1'b0, div_rem};

	assign div_start    = cmd.start_div1 | cmd.start_div2;
	assign div_dividend = cmd.start_div1 ? cyc_q : {1'b0, sum, 14'b0};
	assign div_steps    = cmd.start_div1 ? DIV1_STEPS : DIV2_STEPS;

	ihts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (rate_eff),
		.steps    (div_steps),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_comb begin
		rec_new      = rec_q;
		rec_new.usec = rec_q.usec + {14'b0, div_quot[17:0]};
		rec_new.rem  = div_rem;
	end

	assign mem_we    = cmd.clr_wr | cmd.wr;
	assign mem_addr  = cmd.clr_wr ? clr_q : line_idx;
	assign mem_wdata = cmd.clr_wr ? '0 : rec_new;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (cmd.rd) begin
			rd_q <= mem[line_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q     <= req_kind;
			line_q     <= req_irq_number;
			cyc_q      <= req_handler_cycles;
			in_range_q <= CMP_W'(req_irq_number) < CMP_W'(NUM_LINES);
		end
		if (cmd.eval) begin
			rec_q <= in_range_q ? rd_q : '0;
		end else if (cmd.start_div2) begin
			// first quotient and the count fields settle here
			rec_q.runs  <= rec_q.runs + 32'd1;
			rec_q.worst <= (cyc_q > rec_q.worst) ? cyc_q : rec_q.worst;
			rec_q.usec  <= rec_q.usec + div_quot;
		end else if (cmd.wr) begin
			rec_q <= rec_new;
		end
		if (cmd.load_out) begin
			rsp_line_echo          <= line_q;
			rsp_run_count          <= rec_q.runs;
			rsp_worst_cycles       <= rec_q.worst;
			rsp_total_microseconds <= rec_q.usec;
			rsp_leftover_cycles    <= rec_q.rem;
		end
	end

	assign sts.clr_last = clr_q == IDX_W'(NUM_LINES - 1);
	assign sts.div_busy = div_busy;
	assign sts.skip     = kind_q | ~in_range_q;

endmodule

/* rtl/core/ihts_ctrl.sv */
// controller state machine sequencing clear, read, divide, write and response
module ihts_ctrl
	import ihts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  ihts_sts_t sts,
	output ihts_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DIV1,
		ST_DIV2,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.take       = (state_q == ST_IDLE) && req_valid;
		cmd.clr_wr     = state_q == ST_CLEAR;
		cmd.rd         = state_q == ST_READ;
		cmd.eval       = state_q == ST_EVAL;
		cmd.start_div1 = (state_q == ST_EVAL) && !sts.skip;
		cmd.start_div2 = (state_q == ST_DIV1) && !sts.div_busy;
		cmd.wr         = (state_q == ST_DIV2) && !sts.div_busy;
		cmd.load_out   = (state_q == ST_FIN) && (!rsp_valid_q || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid) state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= sts.skip ? ST_FIN : ST_DIV1;
				end
				ST_DIV1: begin
					if (!sts.div_busy) state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (!sts.div_busy) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (cmd.load_out) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = rsp_valid_q;

endmodule

/* rtl/core/irq_handler_time_stats_unit.sv */
// top level of the interrupt handler time statistics block
// account word: response after table read, 16-step radix-4 divide of the
// cycle count and 9-step fold of the remainder, next accept once the response is loaded
// query word or line beyond the table: no divides, response loaded before next accept
// a stalled response word holds in its register while the next word is worked on
// reset: clearing pass over every line of the table before the first accept, rate to 24
module irq_handler_time_stats_unit
	import ihts_pkg::*;
#(
	parameter int NUM_LINES = NUM_LINES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_wdata,
	ihts_req_if.sink          req,
	ihts_rsp_if.source        rsp
);

	ihts_cmd_t cmd;
	ihts_sts_t sts;

	ihts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ihts_dp #(
		.NUM_LINES (NUM_LINES)
	) u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_we                 (cfg_we),
		.cfg_wdata              (cfg_wdata),
		.cmd                    (cmd),
		.sts                    (sts),
		.req_kind               (req.kind),
		.req_irq_number         (req.irq_number),
		.req_handler_cycles     (req.handler_cycles),
		.rsp_line_echo          (rsp.line_echo),
		.rsp_run_count          (rsp.run_count),
		.rsp_worst_cycles       (rsp.worst_cycles),
		.rsp_total_microseconds (rsp.total_microseconds),
		.rsp_leftover_cycles    (rsp.leftover_cycles)
	);

endmodule

/* rtl/core/ihts_checker.sv */
// port-level assertions for the statistics block and their bind
module ihts_checker
	import ihts_pkg::*;
#(
	parameter int NUM_LINES = NUM_LINES_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [LINE_W-1:0] rsp_line_echo,
	input logic [31:0]       rsp_run_count,
	input logic [31:0]       rsp_worst_cycles,
	input logic [31:0]       rsp_total_microseconds,
	input logic [15:0]       rsp_leftover_cycles
);

	// one word in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous word still in work");

	// a line beyond the table reports an empty record
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (int'(rsp_line_echo) >= NUM_LINES) |->
		rsp_run_count == '0 && rsp_worst_cycles == '0 &&
		rsp_total_microseconds == '0 && rsp_leftover_cycles == '0)
		else $error("out of range line returned a nonzero record");

	// remainder always below the largest rate
	a_leftover_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_leftover_cycles != 16'hFFFF)
		else $error("leftover cycles at or above the rate limit");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_echo) &&
		$stable(rsp_run_count) && $stable(rsp_total_microseconds))
		else $error("stalled response word changed");

endmodule

bind irq_handler_time_stats_unit ihts_checker #(
	.NUM_LINES (NUM_LINES)
) u_ihts_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.req_valid              (req.valid),
	.req_ready              (req.ready),
	.rsp_valid              (rsp.valid),
	.rsp_ready              (rsp.ready),
	.rsp_line_echo          (rsp.line_echo),
	.rsp_run_count          (rsp.run_count),
	.rsp_worst_cycles       (rsp.worst_cycles),
	.rsp_total_microseconds (rsp.total_microseconds),
	.rsp_leftover_cycles    (rsp.leftover_cycles)
);

/* sim/testbench.sv */
// self-checking testbench for the interrupt handler time statistics block
module testbench;
	import ihts_pkg::*;

	localparam logic KIND_ACCOUNT = 1'b0;
	localparam logic KIND_QUERY = 1'b1;
	localparam int LINES = NUM_LINES_DEF;
	localparam int IDLE_PCT = 37;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_WORDS = 1850;
	localparam int RATE_PHASES = 7;

	typedef struct {
		logic [LINE_W-1:0] line;
		rec_t              rec;
	} line_report_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [RATE_W-1:0] cfg_wdata;

	ihts_req_if req_ch ();
	ihts_rsp_if rsp_ch ();

	irq_handler_time_stats_unit #(
		.NUM_LINES(LINES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	rec_t              line_stats [LINES];
	logic [RATE_W-1:0] cur_rate;
	line_report_t      pending_reports [$];
	bit                steady;
	int                fails;
	int                words_sent;
	int                accounts_sent;
	int                reports_checked;
	int                rate_writes;
	int                idle_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// record of the line after this word, updating the local copy of the table
	function automatic line_report_t account_or_read(input logic kind,
		input logic [LINE_W-1:0] line, input logic [CYC_W-1:0] cyc);
		line_report_t rep;
		logic [31:0]  rate;
		logic [31:0]  carry;
		rep.line = line;
		rep.rec = '0;
		rate = (cur_rate == '0) ? 32'd1 : {16'd0, cur_rate};
		if (line < LINES) begin
			if (kind == KIND_ACCOUNT) begin
				// stored remainder plus this run's remainder, folded with the current rate
				carry = {16'd0, line_stats[line].rem} + cyc % rate;
				line_stats[line].runs = line_stats[line].runs + 32'd1;
				if (cyc > line_stats[line].worst) begin
					line_stats[line].worst = cyc;
				end
				line_stats[line].usec = line_stats[line].usec + cyc / rate + carry / rate;
				line_stats[line].rem = 16'(carry % rate);
			end
			rep.rec = line_stats[line];
		end
		return rep;
	endfunction

	function automatic logic [CYC_W-1:0] pick_cycles();
		logic [31:0] rate;
		rate = (cur_rate == '0) ? 32'd1 : {16'd0, cur_rate};
		case ($urandom_range(9, 0))
			0, 1, 2: return $urandom_range(rate * 4, 0);
			3: return rate - 32'd1 + $urandom_range(2, 0);
			4: return 32'hFFFF_FFFF - $urandom_range(3, 0);
			5: return '0;
			6: return $urandom_range(65535, 0);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_word(input logic kind, input logic [LINE_W-1:0] line,
		input logic [CYC_W-1:0] cyc);
		int gap;
		gap = 0;
		while (!steady && $urandom_range(99, 0) < IDLE_PCT) gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.irq_number <= line;
		req_ch.handler_cycles <= cyc;
		do @(posedge clk); while (!req_ch.ready);
		pending_reports.push_back(account_or_read(kind, line, cyc));
		words_sent++;
		if (kind == KIND_ACCOUNT) accounts_sent++;
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	task automatic write_rate(input logic [RATE_W-1:0] value);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_rate = value;
		rate_writes++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		line_report_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: response for line %0d with no word outstanding, expected none",
					$time, rsp_ch.line_echo);
				fails++;
			end else begin
				want = pending_reports.pop_front();
				check_field("line_echo", 32'(want.line), 32'(rsp_ch.line_echo));
				check_field("run_count", want.rec.runs, rsp_ch.run_count);
				check_field("worst_cycles", want.rec.worst, rsp_ch.worst_cycles);
				check_field("total_microseconds", want.rec.usec, rsp_ch.total_microseconds);
				check_field("leftover_cycles", 32'(want.rec.rem), 32'(rsp_ch.leftover_cycles));
				reports_checked++;
			end
		end
	end

	always @(posedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// reset rate, edges of the cycle count, fold of the remainder, never-written line
	task automatic test_directed_records();
		send_word(KIND_ACCOUNT, 7'd0, 32'd0);
		send_word(KIND_ACCOUNT, 7'd127, 32'hFFFF_FFFF);
		send_word(KIND_ACCOUNT, 7'd5, 32'd23);
		send_word(KIND_ACCOUNT, 7'd5, 32'd1);
		send_word(KIND_ACCOUNT, 7'd5, 32'd10);
		send_word(KIND_QUERY, 7'd5, 32'hFFFF_FFFF);
		send_word(KIND_QUERY, 7'd64, 32'h1234_5678);
		send_word(KIND_ACCOUNT, 7'd1, 32'h5555_5555);
		send_word(KIND_ACCOUNT, 7'd2, 32'hAAAA_AAAA);
		send_word(KIND_QUERY, 7'd127, 32'd0);
	endtask

	// a rate of zero divides as one
	task automatic test_zero_rate();
		write_rate(16'd0);
		send_word(KIND_ACCOUNT, 7'd20, 32'hFFFF_FFFF);
		send_word(KIND_ACCOUNT, 7'd20, 32'd7);
	endtask

	task automatic test_rate_extremes();
		write_rate(16'hFFFF);
		send_word(KIND_ACCOUNT, 7'd9, 32'd65534);
		send_word(KIND_ACCOUNT, 7'd9, 32'd65534);
		send_word(KIND_ACCOUNT, 7'd9, 32'hFFFF_FFFF);
		write_rate(16'd1);
		// microsecond total wraps
		send_word(KIND_ACCOUNT, 7'd11, 32'hFFFF_FFFF);
		send_word(KIND_ACCOUNT, 7'd11, 32'hFFFF_FFFF);
	endtask

	// remainder held under a large rate, then folded under a small one
	task automatic test_rate_change_carry();
		write_rate(16'hFFFF);
		send_word(KIND_ACCOUNT, 7'd10, 32'd40000);
		write_rate(16'd3);
		send_word(KIND_ACCOUNT, 7'd10, 32'd4);
		send_word(KIND_QUERY, 7'd10, 32'd0);
	endtask

	task automatic test_random_traffic();
		logic [RATE_W-1:0] rates [RATE_PHASES];
		logic [LINE_W-1:0] line;
		logic              kind;
		int                share;
		rates[0] = RATE_RESET;
		rates[1] = 16'd1;
		rates[2] = 16'hFFFF;
		rates[3] = 16'd0;
		rates[4] = 16'($urandom_range(100, 2));
		rates[5] = 16'($urandom_range(65535, 1));
		rates[6] = 16'd7;
		share = RANDOM_WORDS / RATE_PHASES;
		for (int p = 0; p < RATE_PHASES; p++) begin
			write_rate(rates[p]);
			steady = (p == 4);
			for (int i = 0; i < share; i++) begin
				if (p == 2 && i == share / 2) wait_for_results();
				kind = ($urandom_range(99, 0) < 70) ? KIND_ACCOUNT : KIND_QUERY;
				// a few hot lines so records build up over many runs
				line = ($urandom_range(99, 0) < 40) ? LINE_W'($urandom_range(3, 0))
					: LINE_W'($urandom_range(LINES - 1, 0));
				send_word(kind, line, (kind == KIND_ACCOUNT) ? pick_cycles() : $urandom());
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_ACCOUNT;
		req_ch.irq_number = '0;
		req_ch.handler_cycles = '0;
		rsp_ch.ready = 1'b0;
		steady = 1'b0;
		fails = 0;
		words_sent = 0;
		accounts_sent = 0;
		reports_checked = 0;
		rate_writes = 0;
		idle_cycles = 0;
		cur_rate = RATE_RESET;
		for (int i = 0; i < LINES; i++) line_stats[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_records();
		test_zero_rate();
		test_rate_extremes();
		test_rate_change_carry();
		test_random_traffic();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d words (%0d account, %0d query) across %0d rate writes",
			words_sent, accounts_sent, words_sent - accounts_sent, rate_writes);
		$display("%0d responses compared field by field, %0d mismatches, %0d left waiting",
			reports_checked, fails, pending_reports.size());
		if (fails == 0 && pending_reports.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/ihts_pkg.sv
rtl/core/ihts_if.sv
rtl/core/ihts_div.sv
rtl/core/ihts_dp.sv
rtl/core/ihts_ctrl.sv
rtl/core/irq_handler_time_stats_unit.sv
rtl/core/ihts_checker.sv
sim/testbench.sv
